// ===== rtl/mlr_pkg.sv =====
// types shared by the midpoint line rasterizer modules
// no dependencies
`default_nettype none

package mlr_pkg;

    typedef struct packed {
        logic y_negated;
        logic axes_swapped;
    } octant_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } step_state_t;

endpackage

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer_top.sv =====
// Midpoint line rasterizer. Each input transaction is a line command with two
// signed endpoints; the block returns the line's pixels from one endpoint to
// the other, one output transaction per pixel, with tlast on the final pixel.
// A command whose endpoints coincide yields no pixels. The front end folds a
// command into one octant in the cycle it is accepted and parks it in a
// QUEUE_DEPTH-deep command queue, so new commands are taken while the stepper
// is busy until the queue fills. The stepper loads a command from the queue
// and steps it pixel by pixel, taking the next command only after the last
// pixel; a command yields max(|dx|, |dy|) + 1 pixels, up to 2**COORD_BITS.
// Output backpressure stalls the stepping. Depends on mlr_pkg.
`default_nettype none

module midpoint_line_rasterizer_top
    import mlr_pkg::*;
#(
    parameter int COORD_BITS  = 6,
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,   // start_x, start_y, end_x, end_y
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,   // pixel_x, pixel_y
    output logic                                   m_tlast    // last_pixel
);

    localparam int IN_W  = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int CMD_W = 6*(COORD_BITS+1) + 8;

    logic             q_push, q_pop, q_full, q_empty;
    logic [CMD_W-1:0] q_push_data, q_pop_data;

    mlr_front #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    mlr_cmd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    mlr_stepper #(
        .COORD_BITS (COORD_BITS),
        .OUT_W      (OUT_W),
        .CMD_W      (CMD_W)
    ) u_stepper (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/mlr_front.sv =====
// front end: accepts line commands, orders endpoints, folds the octant
// and builds the stepper command; depends on mlr_pkg
`default_nettype none

module mlr_front
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int IN_W       = 24,
    parameter int CMD_W      = 50
)
(
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
    input  logic             q_full,
    output logic             q_push,
    output logic [CMD_W-1:0] q_data
);

    localparam int CW = COORD_BITS + 1;
    localparam int DW = CW + 3;

    typedef struct packed {
        octant_t               oct;
        logic signed [CW-1:0]  major_start;
        logic signed [CW-1:0]  major_end;
        logic signed [CW-1:0]  minor_start;
        logic signed [DW-1:0]  decision;
        logic [CW:0]           east_step;
        logic signed [CW+1:0]  diag_step;
    } cmd_t;

    logic signed [COORD_BITS-1:0] ax_raw, ay_raw, bx_raw, by_raw;
    logic signed [CW-1:0] ax, ay, bx, by;
    logic signed [CW-1:0] x0, y0, x1, y1;
    logic signed [CW-1:0] dx, dy, ddx, ddy;
    logic                 y_neg, steep;
    cmd_t                 cmd;

    assign ax_raw = s_tdata[COORD_BITS-1:0];
    assign ay_raw = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign bx_raw = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign by_raw = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign ax = CW'(ax_raw);
    assign ay = CW'(ay_raw);
    assign bx = CW'(bx_raw);
    assign by = CW'(by_raw);

    always_comb
    begin
        if (ax > bx)
        begin
            x0 = bx;
            y0 = by;
            x1 = ax;
            y1 = ay;
        end
        else
        begin
            x0 = ax;
            y0 = ay;
            x1 = bx;
            y1 = by;
        end
        y_neg = y1 < y0;
        if (y_neg)
        begin
            y0 = -y0;
            y1 = -y1;
        end
        dx    = x1 - x0;
        dy    = y1 - y0;
        steep = dy > dx;

        cmd.oct.y_negated    = y_neg;
        cmd.oct.axes_swapped = steep;
        if (steep)
        begin
            cmd.major_start = y0;
            cmd.major_end   = y1;
            cmd.minor_start = x0;
            ddx             = dy;
            ddy             = dx;
        end
        else
        begin
            cmd.major_start = x0;
            cmd.major_end   = x1;
            cmd.minor_start = y0;
            ddx             = dx;
            ddy             = dy;
        end
        cmd.decision  = (DW'(ddy) <<< 1) - DW'(ddx);
        cmd.east_step = {ddy, 1'b0};
        cmd.diag_step = ((CW+2)'(ddy) - (CW+2)'(ddx)) <<< 1;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (ddx != '0);
    assign q_data   = CMD_W'(cmd);

endmodule

`default_nettype wire

// ===== rtl/mlr_cmd_queue.sv =====
// small command queue between the front end and the stepper
// no dependencies
`default_nettype none

module mlr_cmd_queue #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] pop_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = pop_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head entry is registered; a push into the head slot is forwarded
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next))
        begin
            pop_data_reg <= push_data;
        end
        else
        begin
            pop_data_reg <= mem_reg[rd_ptr_next];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mlr_stepper.sv =====
// back end: midpoint stepper that walks one command pixel by pixel and
// unfolds each pixel into the output register; depends on mlr_pkg
`default_nettype none

module mlr_stepper
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int OUT_W      = 16,
    parameter int CMD_W      = 50
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  logic [CMD_W-1:0] q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y
    output logic             m_tlast    // last_pixel
);

    localparam int CW = COORD_BITS + 1;
    localparam int DW = CW + 3;

    typedef struct packed {
        octant_t               oct;
        logic signed [CW-1:0]  major_start;
        logic signed [CW-1:0]  major_end;
        logic signed [CW-1:0]  minor_start;
        logic signed [DW-1:0]  decision;
        logic [CW:0]           east_step;
        logic signed [CW+1:0]  diag_step;
    } cmd_t;

    cmd_t                 cmd;
    step_state_t          state_reg, state_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic signed [CW-1:0] major_pos_reg, major_pos_next;
    logic signed [CW-1:0] major_end_reg, major_end_next;
    logic signed [CW-1:0] minor_pos_reg, minor_pos_next;
    logic [CW:0]          east_step_reg, east_step_next;
    logic signed [CW+1:0] diag_step_reg, diag_step_next;
    octant_t              oct_reg, oct_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic                 out_free, at_end;
    logic signed [CW-1:0] px, py;

    assign cmd      = cmd_t'(q_data);
    assign out_free = !m_tvalid_reg || m_tready;
    assign at_end   = major_pos_reg >= major_end_reg;

    always_comb
    begin
        if (oct_reg.axes_swapped)
        begin
            px = minor_pos_reg;
            py = major_pos_reg;
        end
        else
        begin
            px = major_pos_reg;
            py = minor_pos_reg;
        end
        if (oct_reg.y_negated)
        begin
            py = -py;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        decision_next  = decision_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        minor_pos_next = minor_pos_reg;
        east_step_next = east_step_reg;
        diag_step_next = diag_step_reg;
        oct_next       = oct_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    decision_next  = cmd.decision;
                    major_pos_next = cmd.major_start;
                    major_end_next = cmd.major_end;
                    minor_pos_next = cmd.minor_start;
                    east_step_next = cmd.east_step;
                    diag_step_next = cmd.diag_step;
                    oct_next       = cmd.oct;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[2*COORD_BITS-1:0] = {py[COORD_BITS-1:0], px[COORD_BITS-1:0]};
                    m_tlast_next  = at_end;
                    if (at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (decision_reg <= 0)
                        begin
                            decision_next = decision_reg + DW'(signed'({1'b0, east_step_reg}));
                        end
                        else
                        begin
                            decision_next  = decision_reg + DW'(diag_step_reg);
                            minor_pos_next = minor_pos_reg + 1'b1;
                        end
                        major_pos_next = major_pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            decision_reg  <= '0;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            minor_pos_reg <= '0;
            east_step_reg <= '0;
            diag_step_reg <= '0;
            oct_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            decision_reg  <= decision_next;
            major_pos_reg <= major_pos_next;
            major_end_reg <= major_end_next;
            minor_pos_reg <= minor_pos_next;
            east_step_reg <= east_step_next;
            diag_step_reg <= diag_step_next;
            oct_reg       <= oct_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tlast_reg   <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/mlr_checker.sv =====
// port-level checks for the midpoint line rasterizer, bound to the top level
// depends on midpoint_line_rasterizer_top
`default_nettype none

module mlr_checker #(
    parameter int COORD_BITS = 6,
    parameter int OUT_W      = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast
);

    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                  in_line_reg;
    logic [COORD_BITS:0]   count_reg, count_next;
    logic [COORD_BITS-1:0] cur_x, cur_y, diff_x, diff_y;
    logic                  out_acc, step_ok;

    assign out_acc = m_tvalid && m_tready;
    assign cur_x   = m_tdata[COORD_BITS-1:0];
    assign cur_y   = m_tdata[2*COORD_BITS-1:COORD_BITS];
    assign diff_x  = cur_x - prev_x_reg;
    assign diff_y  = cur_y - prev_y_reg;
    assign step_ok = (diff_x == '0 || diff_x == COORD_BITS'(1))
                  && (diff_y == '0 || diff_y == COORD_BITS'(1) || diff_y == '1)
                  && !(diff_x == '0 && diff_y == '0);
    assign count_next = m_tlast ? '0 : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            in_line_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (out_acc)
        begin
            prev_x_reg  <= cur_x;
            prev_y_reg  <= cur_y;
            in_line_reg <= !m_tlast;
            count_reg   <= count_next;
        end
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && in_line_reg |-> step_ok)
        else $error("consecutive pixels of a line are not neighbors");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> !count_reg[COORD_BITS])
        else $error("line longer than the coordinate range allows");

endmodule

bind midpoint_line_rasterizer_top mlr_checker #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W)
) u_mlr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/tb_midpoint_line_rasterizer_top.sv =====
// testbench for midpoint_line_rasterizer_top: sends line commands and checks every pixel
// against a behavioral line stepper kept in this file. depends on mlr_pkg and the rtl top
`default_nettype none

module tb_midpoint_line_rasterizer_top
    import mlr_pkg::*;
();

    localparam int COORD_BITS  = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 200;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // start_x, start_y, end_x, end_y
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // pixel_x, pixel_y, zero pad
    logic        m_tlast;         // last_pixel

    pixel_t expected_pixels[$];
    int     failures   = 0;
    bit     idle_on    = 1'b1;
    int     ready_hold = 0;
    int     quiet_cycles = 0;

    midpoint_line_rasterizer_top #(
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // expected pixels of one line, midpoint stepping in the first octant
    function automatic void rasterize_line(input coord_t sx, input coord_t sy,
                                           input coord_t ex, input coord_t ey);
        int      ax, ay, bx, by, dx, dy, tmp;
        int      decision, major_pos, major_end, minor_pos, px, py, count;
        octant_t oct;
        pixel_t  pix;
        ax = sx;
        ay = sy;
        bx = ex;
        by = ey;
        count = 0;
        if (ax > bx)
        begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
        end
        oct.y_negated = (by - ay) < 0;
        if (oct.y_negated)
        begin
            ay = -ay;
            by = -by;
        end
        dx = bx - ax;
        dy = by - ay;
        oct.axes_swapped = dy > dx;
        if (oct.axes_swapped)
        begin
            tmp = ax; ax = ay; ay = tmp;
            tmp = bx; bx = by; by = tmp;
            dx = bx - ax;
            dy = by - ay;
        end
        decision  = 2 * dy - dx;
        major_pos = ax;
        major_end = bx;
        minor_pos = ay;
        if (dx <= 0)
            return;
        while (1)
        begin
            px = oct.axes_swapped ? minor_pos : major_pos;
            py = oct.axes_swapped ? major_pos : minor_pos;
            if (oct.y_negated)
                py = -py;
            pix.x    = coord_t'(px);
            pix.y    = coord_t'(py);
            pix.last = major_pos >= major_end;
            expected_pixels.push_back(pix);
            count++;
            if (major_pos >= major_end || count >= (1 << COORD_BITS))
                break;
            if (decision <= 0)
                decision += 2 * dy;
            else
            begin
                decision += 2 * (dy - dx);
                minor_pos++;
            end
            major_pos++;
        end
    endfunction

    function automatic coord_t clamp_coord(input int v);
        if (v < -(1 << (COORD_BITS - 1)))
            return coord_t'(-(1 << (COORD_BITS - 1)));
        if (v > (1 << (COORD_BITS - 1)) - 1)
            return coord_t'((1 << (COORD_BITS - 1)) - 1);
        return coord_t'(v);
    endfunction

    // one command transaction; valid stays high when the next one follows at once
    task automatic send_line(input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey);
        bit accepted;
        if (idle_on && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ey, ex, sy, sx};
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_tready;
            @(posedge clk);
        end
        rasterize_line(sx, sy, ex, ey);
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && rst_n && $urandom_range(7) == 0)
        begin
            ready_hold <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // values are stable from the falling edge up to the accepting rising edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                         $signed(m_tdata[5:0]), $signed(m_tdata[11:6]), m_tlast);
                failures++;
            end
            else if (m_tdata[5:0] !== expected_pixels[0].x ||
                     m_tdata[11:6] !== expected_pixels[0].y ||
                     m_tlast !== expected_pixels[0].last)
            begin
                $display(
                    "%0t: mismatch, expected x=%0d y=%0d last=%0b, actual x=%0d y=%0d last=%0b",
                    $time, expected_pixels[0].x, expected_pixels[0].y,
                    expected_pixels[0].last, $signed(m_tdata[5:0]),
                    $signed(m_tdata[11:6]), m_tlast);
                failures++;
                void'(expected_pixels.pop_front());
            end
            else
                void'(expected_pixels.pop_front());
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic test_directed_lines();
        send_line(-32, -32,  31,  31);
        send_line( 31,  31, -32, -32);
        send_line(-32,  31,  31, -32);
        send_line( 31, -32, -32,  31);
        send_line(-32,   0,  31,   0);
        send_line( 31,   5, -32,   5);
        send_line(  0, -32,   0,  31);
        send_line(  3,  31,   3, -32);
        send_line(  5,   5,   5,   5);
        send_line(-32, -32, -32, -32);
        send_line( 31,  31,  31,  31);
        send_line( -4,   2,   6,  12);
        send_line( -4,   2,   6,  -8);
        send_line(-10, -20,  -5,  25);
        send_line( 20,  25,  17, -30);
        send_line(-30,  -7,  29,   4);
        send_line( 12,  -1, -21,  10);
        send_line(  0,   0,   1,   0);
        send_line(  0,   0,   0,   1);
        send_line(  1,   1,   0,   0);
    endtask

    task automatic random_line();
        coord_t sx, sy, ex, ey;
        int     d;
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
        case ($urandom_range(9))
            0:
            begin
                ex = sx;
                ey = sy;
            end
            1:
            begin
                if ($urandom_range(1))
                    ey = sy;
                else
                    ex = sx;
            end
            2:
            begin
                d  = int'(ex) - int'(sx);
                d  = d < 0 ? -d : d;
                ey = $urandom_range(1) ? clamp_coord(int'(sy) + d) : clamp_coord(int'(sy) - d);
                if (ey != int'(sy) + d && ey != int'(sy) - d)
                    ey = sy;
            end
            3, 4:
            begin
                ex = clamp_coord(int'(sx) + $urandom_range(0, 8) - 4);
                ey = clamp_coord(int'(sy) + $urandom_range(0, 8) - 4);
            end
            default:
            begin
            end
        endcase
        send_line(sx, sy, ex, ey);
    endtask

    task automatic test_random_lines();
        for (int i = 0; i < 400; i++)
        begin
            idle_on = (i % 100) < 80;
            random_line();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int i = 0; i < 50; i++)
            random_line();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_lines();
        test_random_lines();
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
            failures++;
        end
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== midpoint_line_rasterizer_top.f =====
rtl/mlr_pkg.sv
rtl/mlr_front.sv
rtl/mlr_cmd_queue.sv
rtl/mlr_stepper.sv
rtl/midpoint_line_rasterizer_top.sv
rtl/mlr_checker.sv
verif/tb_midpoint_line_rasterizer_top.sv
